// ----- rtl/mbwp_pkg.sv -----
// Shared constants, types and word formats of the multichannel boxcar averager.
package mbwp_pkg;

    localparam int CHANNELS    = 13;
    localparam int FILTER_LEN  = 16;
    localparam int PEAK_DEPTH  = 50;
    localparam int QUEUE_DEPTH = 2;

    localparam int CHF_W    = 4;
    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 8;

    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W      = $clog2(FILTER_LEN);
    localparam int SUM_W      = SAMPLE_W + POS_W;
    localparam int RING_DEPTH = CHANNELS * FILTER_LEN;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int PK_W       = $clog2(PEAK_DEPTH);
    localparam int Q_AW       = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_DROP,
        KIND_AVG,
        KIND_PEAK
    } kind_t;

    typedef struct packed {
        logic [CHF_W-1:0]    channel;
        logic [SAMPLE_W-1:0] sample;
        kind_t               kind;
    } word_t;

endpackage

// ----- rtl/mbwp_ram.sv -----
// Generic simple dual-port RAM with registered read.
module mbwp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mbwp_front.sv -----
// Input stage: take a word, classify it and hand it to the queue.
module mbwp_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mbwp_pkg::CHF_W-1:0]        channel,
    input  logic [mbwp_pkg::SAMPLE_W-1:0]     sample,
    input  logic [mbwp_pkg::CHF_W-1:0]        peak_channel,
    output logic                              push,
    output mbwp_pkg::word_t                   push_word,
    input  logic                              q_full
);

    logic            valid_reg;
    logic            valid_next;
    mbwp_pkg::word_t word_reg;
    mbwp_pkg::word_t word_next;
    logic            accept;

    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !q_full;

    always_comb
    begin
        word_next         = word_reg;
        valid_next        = valid_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next        = 1'b1;
            word_next.channel = channel;
            word_next.sample  = sample;
            if (32'(channel) >= mbwp_pkg::CHANNELS)
            begin
                word_next.kind = mbwp_pkg::KIND_DROP;
            end
            else if (channel == peak_channel)
            begin
                word_next.kind = mbwp_pkg::KIND_PEAK;
            end
            else
            begin
                word_next.kind = mbwp_pkg::KIND_AVG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            word_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            word_reg  <= word_next;
        end
    end

    assign push_word = word_reg;

endmodule

// ----- rtl/mbwp_queue.sv -----
// Short word queue between the input stage and the filter engine.
module mbwp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbwp_pkg::word_t push_word,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output mbwp_pkg::word_t q_word
);

    mbwp_pkg::word_t               entry_reg [mbwp_pkg::QUEUE_DEPTH];
    logic [mbwp_pkg::Q_AW-1:0]     wr_ptr_reg;
    logic [mbwp_pkg::Q_AW-1:0]     rd_ptr_reg;
    logic [mbwp_pkg::Q_AW:0]       count_reg;
    logic [mbwp_pkg::Q_AW:0]       count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (32'(count_reg) == mbwp_pkg::QUEUE_DEPTH);
    assign q_valid = (count_reg != '0);
    assign q_word  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            for (int i = 0; i < mbwp_pkg::QUEUE_DEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                entry_reg[wr_ptr_reg] <= push_word;
                wr_ptr_reg            <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/mbwp_back.sv -----
// Filter engine: ring update, running sums and the peak window scan.
module mbwp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  mbwp_pkg::word_t               q_word,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mbwp_pkg::CHF_W-1:0]    out_channel,
    output logic [mbwp_pkg::SAMPLE_W-1:0] average,
    output logic [mbwp_pkg::PEAK_W-1:0]   peak,
    output logic                          peak_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_TAIL,
        S_DONE
    } state_t;

    state_t                          state_reg;
    mbwp_pkg::word_t                 item_reg;
    logic [mbwp_pkg::POS_W-1:0]      item_pos_reg;
    logic [mbwp_pkg::SUM_W-1:0]      sums_reg [mbwp_pkg::CHANNELS];
    logic [mbwp_pkg::POS_W-1:0]      pos_reg [mbwp_pkg::CHANNELS];
    logic [mbwp_pkg::CHANNELS-1:0]   wrapped_reg;
    logic [mbwp_pkg::PK_W-1:0]       widx_reg;
    logic                            full_reg;
    logic [mbwp_pkg::PK_W-1:0]       scan_idx_reg;
    logic [mbwp_pkg::PK_W-1:0]       cmp_idx_reg;
    logic                            cmp_valid_reg;
    logic [mbwp_pkg::PEAK_W-1:0]     best_reg;
    logic [mbwp_pkg::PEAK_W-1:0]     best_next;
    logic [mbwp_pkg::CHF_W-1:0]      out_channel_reg;
    logic [mbwp_pkg::SAMPLE_W-1:0]   average_reg;
    logic [mbwp_pkg::PEAK_W-1:0]     peak_reg;
    logic                            peak_valid_reg;

    logic [mbwp_pkg::CH_W-1:0]       ch_idx;
    logic [mbwp_pkg::CH_W-1:0]       q_idx;
    logic                            ring_re;
    logic [mbwp_pkg::RING_AW-1:0]    ring_raddr;
    logic                            ring_we;
    logic [mbwp_pkg::RING_AW-1:0]    ring_waddr;
    logic [mbwp_pkg::SAMPLE_W-1:0]   ring_rdata;
    logic [mbwp_pkg::SAMPLE_W-1:0]   old_sample;
    logic [mbwp_pkg::SUM_W-1:0]      new_sum;
    logic                            hist_we;
    logic                            hist_re;
    logic [mbwp_pkg::PEAK_W-1:0]     hist_rdata;
    logic [mbwp_pkg::PEAK_W-1:0]     hist_entry;

    assign ch_idx = mbwp_pkg::CH_W'(item_reg.channel);
    assign q_idx  = mbwp_pkg::CH_W'(q_word.channel);
    assign q_pop  = (state_reg == S_IDLE) && q_valid;

    assign ring_re    = q_pop && (q_word.kind != mbwp_pkg::KIND_DROP);
    assign ring_raddr = mbwp_pkg::RING_AW'({q_idx, pos_reg[q_idx]});
    assign ring_we    = (state_reg == S_UPDATE);
    assign ring_waddr = mbwp_pkg::RING_AW'({ch_idx, item_pos_reg});

    // entries not yet written since reset read as zero
    assign old_sample = wrapped_reg[ch_idx] ? ring_rdata : '0;
    assign new_sum    = sums_reg[ch_idx] - mbwp_pkg::SUM_W'(old_sample)
                        + mbwp_pkg::SUM_W'(item_reg.sample);

    assign hist_we    = (state_reg == S_UPDATE) && (item_reg.kind == mbwp_pkg::KIND_PEAK);
    assign hist_re    = (state_reg == S_SCAN);
    assign hist_entry = (full_reg || (cmp_idx_reg < widx_reg)) ? hist_rdata : '0;
    assign best_next  = (cmp_valid_reg && (hist_entry > best_reg)) ? hist_entry : best_reg;

    mbwp_ram #(
        .WIDTH (mbwp_pkg::SAMPLE_W),
        .DEPTH (mbwp_pkg::RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (item_reg.sample),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    mbwp_ram #(
        .WIDTH (mbwp_pkg::PEAK_W),
        .DEPTH (mbwp_pkg::PEAK_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (widx_reg),
        .wdata (item_reg.sample[mbwp_pkg::PEAK_W-1:0]),
        .re    (hist_re),
        .raddr (scan_idx_reg),
        .rdata (hist_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            item_reg        <= '0;
            item_pos_reg    <= '0;
            wrapped_reg     <= '0;
            widx_reg        <= '0;
            full_reg        <= 1'b0;
            scan_idx_reg    <= '0;
            cmp_idx_reg     <= '0;
            cmp_valid_reg   <= 1'b0;
            best_reg        <= '0;
            out_channel_reg <= '0;
            average_reg     <= '0;
            peak_reg        <= '0;
            peak_valid_reg  <= 1'b0;
            for (int i = 0; i < mbwp_pkg::CHANNELS; i++)
            begin
                sums_reg[i] <= '0;
                pos_reg[i]  <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg        <= q_word;
                        item_pos_reg    <= pos_reg[q_idx];
                        out_channel_reg <= q_word.channel;
                        if (q_word.kind == mbwp_pkg::KIND_DROP)
                        begin
                            average_reg    <= '0;
                            peak_reg       <= '0;
                            peak_valid_reg <= 1'b0;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE:
                begin
                    sums_reg[ch_idx] <= new_sum;
                    pos_reg[ch_idx]  <= item_pos_reg + 1'b1;
                    if (32'(item_pos_reg) == mbwp_pkg::FILTER_LEN - 1)
                    begin
                        wrapped_reg[ch_idx] <= 1'b1;
                    end
                    average_reg <= new_sum[mbwp_pkg::SUM_W-1:mbwp_pkg::POS_W];
                    if (item_reg.kind == mbwp_pkg::KIND_PEAK)
                    begin
                        if (32'(widx_reg) == mbwp_pkg::PEAK_DEPTH - 1)
                        begin
                            widx_reg <= '0;
                            full_reg <= 1'b1;
                        end
                        else
                        begin
                            widx_reg <= widx_reg + 1'b1;
                        end
                        scan_idx_reg  <= '0;
                        cmp_valid_reg <= 1'b0;
                        best_reg      <= '0;
                        state_reg     <= S_SCAN;
                    end
                    else
                    begin
                        peak_reg       <= '0;
                        peak_valid_reg <= 1'b0;
                        state_reg      <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    best_reg      <= best_next;
                    cmp_valid_reg <= 1'b1;
                    cmp_idx_reg   <= scan_idx_reg;
                    if (32'(scan_idx_reg) == mbwp_pkg::PEAK_DEPTH - 1)
                    begin
                        state_reg <= S_TAIL;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                S_TAIL:
                begin
                    peak_reg       <= best_next;
                    peak_valid_reg <= 1'b1;
                    state_reg      <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = (state_reg == S_DONE);
    assign out_channel = out_channel_reg;
    assign average     = average_reg;
    assign peak        = peak_reg;
    assign peak_valid  = peak_valid_reg;

endmodule

// ----- rtl/multichannel_boxcar_with_window_peak.sv -----
// Top level of the multichannel boxcar averager with windowed peak detector.
//
// Input channel: in_valid/in_stall with channel and sample; a word is taken on a rising
// edge with in_valid high and in_stall low. Output channel: out_valid/out_stall with
// out_channel, average, peak and peak_valid, one result word per input word, in order.
// cfg_write/cfg_data set the peak channel; write only while the block is idle.
// Path: a taken word is registered in the input stage, passes the queue, and the engine
// steps through update and done; an unused channel number goes straight to done, and a
// word on the peak channel adds a scan and a tail step. The engine takes a new word only
// once its last result has left; peak channel words are held longest, by the scan of
// the 50-entry history RAM through its single read port, one per cycle.
// An input stage and a two-word queue take further words while the engine works or
// while a result waits, so in_stall rises only once both are full.
// While out_stall is high the result word holds and the engine waits.
// Reset clears the sums, ring positions and peak channel and marks the rings and peak
// history empty at once: no clearing pass, the block takes words as soon as reset ends.
module multichannel_boxcar_with_window_peak (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mbwp_pkg::CHF_W-1:0]    channel,
    input  logic [mbwp_pkg::SAMPLE_W-1:0] sample,
    input  logic                          cfg_write,
    input  logic [mbwp_pkg::CHF_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mbwp_pkg::CHF_W-1:0]    out_channel,
    output logic [mbwp_pkg::SAMPLE_W-1:0] average,
    output logic [mbwp_pkg::PEAK_W-1:0]   peak,
    output logic                          peak_valid
);

    logic [mbwp_pkg::CHF_W-1:0] peak_channel_reg;
    logic                       push;
    mbwp_pkg::word_t            push_word;
    logic                       q_full;
    logic                       q_pop;
    logic                       q_valid;
    mbwp_pkg::word_t            q_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_channel_reg <= '0;
        end
        else if (cfg_write)
        begin
            peak_channel_reg <= cfg_data;
        end
    end

    mbwp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .channel      (channel),
        .sample       (sample),
        .peak_channel (peak_channel_reg),
        .push         (push),
        .push_word    (push_word),
        .q_full       (q_full)
    );

    mbwp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_word    (q_word)
    );

    mbwp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_channel (out_channel),
        .average     (average),
        .peak        (peak),
        .peak_valid  (peak_valid)
    );

    a_peak_on_peak_channel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && peak_valid |-> out_channel == peak_channel_reg)
        else $error("peak reported for a channel other than the peak channel");

    a_unused_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (32'(out_channel) >= mbwp_pkg::CHANNELS)
        |-> average == '0 && peak == '0 && !peak_valid)
        else $error("result for an unused channel is not all zero");

    a_no_peak_without_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !peak_valid |-> peak == '0)
        else $error("peak field set without peak_valid");

    a_stall_only_when_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_full)
        else $error("input stalled while the queue has room");

endmodule

// ----- bench/multichannel_boxcar_with_window_peak_test.sv -----
// Self-checking bench for the multichannel boxcar averager with windowed peak detector.
module multichannel_boxcar_with_window_peak_test;

    import mbwp_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 190;
    localparam int DIR_ROWS       = 16;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [CHF_W-1:0]    ch;
        logic [SAMPLE_W-1:0] avg;
        logic [PEAK_W-1:0]   pk;
        logic                pk_ok;
    } smooth_word_t;

    typedef struct packed {
        logic [CHF_W-1:0]    ch;
        logic [SAMPLE_W-1:0] smp;
        logic                typed;
        smooth_word_t        want;
    } stim_row_t;

    // peak channel is 0 throughout this table
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{4'd0,  16'hFFFF, 1'b1, '{4'd0,  16'h0FFF, 8'hFF, 1'b1}},
        '{4'd0,  16'h0000, 1'b1, '{4'd0,  16'h0FFF, 8'hFF, 1'b1}},
        '{4'd12, 16'hFFFF, 1'b1, '{4'd12, 16'h0FFF, 8'h00, 1'b0}},
        '{4'd13, 16'h1234, 1'b1, '{4'd13, 16'h0000, 8'h00, 1'b0}},
        '{4'd14, 16'h0000, 1'b1, '{4'd14, 16'h0000, 8'h00, 1'b0}},
        '{4'd15, 16'hFFFF, 1'b1, '{4'd15, 16'h0000, 8'h00, 1'b0}},
        '{4'd1,  16'h000F, 1'b1, '{4'd1,  16'h0000, 8'h00, 1'b0}},
        '{4'd1,  16'h0001, 1'b1, '{4'd1,  16'h0001, 8'h00, 1'b0}},
        '{4'd0,  16'h0080, 1'b1, '{4'd0,  16'h1007, 8'hFF, 1'b1}},
        '{4'd5,  16'hAAAA, 1'b0, '0},
        '{4'd5,  16'h5555, 1'b0, '0},
        '{4'd12, 16'hFFFF, 1'b0, '0},
        '{4'd0,  16'h7F00, 1'b0, '0},
        '{4'd3,  16'h8001, 1'b0, '0},
        '{4'd15, 16'h0000, 1'b1, '{4'd15, 16'h0000, 8'h00, 1'b0}},
        '{4'd11, 16'hFFFE, 1'b0, '0}
    };

    localparam logic [CHF_W-1:0] PHASE_SEL [PHASES] = '{4'd12, 4'd15, 4'd0, 4'd7, 4'd13, 4'd3};

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [CHF_W-1:0]    channel   = '0;
    logic [SAMPLE_W-1:0] sample    = '0;
    logic                cfg_write = 1'b0;
    logic [CHF_W-1:0]    cfg_data  = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [CHF_W-1:0]    out_channel;
    logic [SAMPLE_W-1:0] average;
    logic [PEAK_W-1:0]   peak;
    logic                peak_valid;

    logic [SAMPLE_W-1:0] ring_mem [CHANNELS][FILTER_LEN];
    logic [SUM_W-1:0]    ring_sum [CHANNELS];
    int                  ring_wr  [CHANNELS];
    logic [PEAK_W-1:0]   hist_mem [PEAK_DEPTH];
    int                  hist_wr;
    logic [CHF_W-1:0]    peak_sel;

    smooth_word_t pending_words [$];
    bit           calm = 1'b1;
    int           errors = 0;
    int           words_in = 0;
    int           words_out = 0;
    int           peak_words = 0;
    int           cfg_writes = 0;
    int           stall_left = 0;

    multichannel_boxcar_with_window_peak uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .channel     (channel),
        .sample      (sample),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_channel (out_channel),
        .average     (average),
        .peak        (peak),
        .peak_valid  (peak_valid)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int pause_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 80);
    endfunction

    function automatic smooth_word_t filter_step(input logic [CHF_W-1:0] ch,
                                                 input logic [SAMPLE_W-1:0] smp);
        smooth_word_t res;
        logic [PEAK_W-1:0] best;
        int pos;
        res = '0;
        res.ch = ch;
        if (ch >= CHANNELS)
            return res;
        pos = ring_wr[ch];
        ring_sum[ch] = ring_sum[ch] - SUM_W'(ring_mem[ch][pos]) + SUM_W'(smp);
        ring_mem[ch][pos] = smp;
        ring_wr[ch] = (pos + 1) % FILTER_LEN;
        res.avg = SAMPLE_W'(ring_sum[ch] / FILTER_LEN);
        if (ch == peak_sel)
        begin
            hist_mem[hist_wr] = smp[PEAK_W-1:0];
            hist_wr = (hist_wr + 1) % PEAK_DEPTH;
            best = '0;
            for (int k = 0; k < PEAK_DEPTH; k++)
                if (hist_mem[k] > best)
                    best = hist_mem[k];
            res.pk = best;
            res.pk_ok = 1'b1;
        end
        return res;
    endfunction

    function automatic void note_fault(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    task automatic send_word(input logic [CHF_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                             input bit typed, input smooth_word_t want);
        int gap;
        smooth_word_t predicted;
        gap = (calm || $urandom_range(0, 99) < 60) ? 0 : pause_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        channel  <= ch;
        sample   <= smp;
        do @(posedge clk); while (in_stall);
        predicted = filter_step(ch, smp);
        pending_words.push_back(typed ? want : predicted);
        words_in++;
        if (predicted.pk_ok)
            peak_words++;
        @(negedge clk);
    endtask

    task automatic drain_words();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_peak_channel(input logic [CHF_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        peak_sel = value;
        cfg_writes++;
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            stall_left = pause_len() - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        smooth_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            words_out++;
            if (pending_words.size() == 0)
                note_fault($sformatf("unexpected word: ch=%0d avg=%h peak=%h pv=%b",
                                     out_channel, average, peak, peak_valid));
            else
            begin
                exp_w = pending_words.pop_front();
                if (out_channel !== exp_w.ch || average !== exp_w.avg ||
                    peak !== exp_w.pk || peak_valid !== exp_w.pk_ok)
                    note_fault($sformatf(
                        "expected ch=%0d avg=%h pk=%h pv=%b, got ch=%0d avg=%h pk=%h pv=%b",
                        exp_w.ch, exp_w.avg, exp_w.pk, exp_w.pk_ok,
                        out_channel, average, peak, peak_valid));
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog expired with %0d words outstanding", pending_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [CHF_W-1:0]    ch;
        logic [SAMPLE_W-1:0] smp;
        logic [CHF_W-1:0]    sel;
        int                  byte_cap;
        int                  roll;

        for (int c = 0; c < CHANNELS; c++)
        begin
            ring_sum[c] = '0;
            ring_wr[c]  = 0;
            for (int k = 0; k < FILTER_LEN; k++)
                ring_mem[c][k] = '0;
        end
        for (int k = 0; k < PEAK_DEPTH; k++)
            hist_mem[k] = '0;
        hist_wr  = 0;
        peak_sel = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(DIR_TABLE[i].ch, DIR_TABLE[i].smp, DIR_TABLE[i].typed,
                      DIR_TABLE[i].want);
        drain_words();

        for (int p = 0; p < PHASES; p++)
        begin
            sel = (p == PHASES - 1) ? CHF_W'($urandom_range(0, 15)) : PHASE_SEL[p];
            write_peak_channel(sel);
            calm = (p == 2);
            // low bytes held small in odd phases so the window maximum can fall
            byte_cap = (p % 2 == 1) ? $urandom_range(4, 100) : 255;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    ch = (sel < CHANNELS) ? sel : CHF_W'($urandom_range(0, CHANNELS - 1));
                else if (roll < 90)
                    ch = CHF_W'($urandom_range(0, CHANNELS - 1));
                else
                    ch = CHF_W'($urandom_range(CHANNELS, 15));
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    smp = '0;
                else if (roll < 10)
                    smp = '1;
                else
                    smp = {SAMPLE_W'($urandom_range(0, 255)) << PEAK_W}
                          | SAMPLE_W'($urandom_range(0, byte_cap));
                send_word(ch, smp, 1'b0, '0);
                if (n == PHASE_WORDS / 2 && p == 1)
                    drain_words();
            end
            drain_words();
        end

        calm = 1'b1;
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_words.size() != 0)
            note_fault($sformatf("%0d expected words never arrived", pending_words.size()));
        $display("Run covered %0d words in, %0d out, %0d on the peak channel",
                 words_in, words_out, peak_words);
        $display("over %0d peak channel settings including out-of-range ones; %0d faults",
                 cfg_writes, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
